// File: sv/spe_pkg.sv
// shared types, constants and the angle-to-compare conversion for the servo pwm block
package spe_pkg;

	// field widths
	localparam int CMD_W       = 1;
	localparam int CHAN_W      = 4;
	localparam int ANGLE_W     = 8;
	localparam int LEVEL_W     = 8;
	localparam int CMP_W       = 11;
	localparam int PRESCALE_W  = 8;
	localparam int PERIOD_W    = 12;

	// configuration port
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 12;
	localparam logic [CFG_IDX_W-1:0] REG_PRESCALE_TOP = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TOP   = 1'd1;

	// register reset values
	localparam logic [PRESCALE_W-1:0] PRESCALE_TOP_RST = 8'd167;
	localparam logic [PERIOD_W-1:0]   PERIOD_TOP_RST   = 12'd2999;

	// parameter defaults
	localparam int CHANNELS_DEF  = 8;
	localparam int MAX_ANGLE_DEF = 180;

	// command codes
	localparam logic [CMD_W-1:0] CMD_TICK      = 1'b0;
	localparam logic [CMD_W-1:0] CMD_SET_ANGLE = 1'b1;

	// compare saturation
	localparam int CMP_MAX = 2047;

	// round(angle*100/9) = floor((100*angle + 4) * 29128 / 2^18), exact for all 8-bit angles
	localparam int RECIP_SHIFT = 18;
	localparam int RECIP_MUL   = 29128;
	localparam int RECIP_SCALE = 100 * RECIP_MUL;
	localparam int RECIP_BIAS  = 4 * RECIP_MUL;
	localparam int PROD_W      = 31;
	localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

	// request item
	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [CHAN_W-1:0]  channel;
		logic [ANGLE_W-1:0] angle;
	} cmd_t;

	// result item
	typedef struct packed {
		logic [LEVEL_W-1:0] pwm_levels;
		logic               period_start;
		logic               accepted;
	} res_t;

	// pulse width in counts for a given angle, saturated to the compare width
	function automatic logic [CMP_W-1:0] angle_to_compare(input logic [ANGLE_W-1:0] angle);
		logic [PROD_W-1:0] prod;
		logic [QUOT_W-1:0] quot;
		prod = PROD_W'(angle) * PROD_W'(RECIP_SCALE) + PROD_W'(RECIP_BIAS);
		quot = prod[PROD_W-1:RECIP_SHIFT];
		if (quot > QUOT_W'(CMP_MAX)) begin
			return CMP_W'(CMP_MAX);
		end
		return quot[CMP_W-1:0];
	endfunction

endpackage

// File: sv/servo_pwm_eight_channel.sv
// servo pulse generator: prescaler, period counter, double-buffered compares, output skid stage
//
//   channel | signals                                  | direction | carries
//   --------+------------------------------------------+-----------+----------------------------
//   cmd     | cmd_valid, cmd_stall, cmd_data           | in        | tick or set-angle request
//   res     | res_valid, res_stall, res_data           | out       | levels, period start, ack
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| in        | prescale_top / period_top
//
// one request per cycle while cmd_stall is low; a result shows the cycle after its request unless one is still waiting.
// the counters, compares and result (or skid) register all update in the clocked step that takes the request.
// reset clears counters and compares and restores both top registers to their defaults.
// a two-entry output (result register plus skid register) absorbs one further request while res_stall holds;
// cmd_stall is raised only while the skid register is occupied.
module servo_pwm_eight_channel #(
	parameter int CHANNELS  = spe_pkg::CHANNELS_DEF,
	parameter int MAX_ANGLE = spe_pkg::MAX_ANGLE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	output logic                            cmd_stall,
	input  spe_pkg::cmd_t                   cmd_data,
	output logic                            res_valid,
	input  logic                            res_stall,
	output spe_pkg::res_t                   res_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [spe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [spe_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int CMP_W      = spe_pkg::CMP_W;
	localparam int PRESCALE_W = spe_pkg::PRESCALE_W;
	localparam int PERIOD_W   = spe_pkg::PERIOD_W;
	localparam int LEVEL_W    = spe_pkg::LEVEL_W;
	localparam int CHSEL_W    = spe_pkg::CHAN_W + 1;
	localparam int ANGCMP_W   = spe_pkg::ANGLE_W + 1;

	// configuration registers
	logic [PRESCALE_W-1:0] prescale_top_q;
	logic [PERIOD_W-1:0]   period_top_q;

	// timer state
	logic [PRESCALE_W-1:0] prescale_q;
	logic [PERIOD_W-1:0]   period_q;
	logic [CMP_W-1:0]      preload_q [CHANNELS];
	logic [CMP_W-1:0]      active_q  [CHANNELS];

	// output stage
	logic          out_valid_q;
	spe_pkg::res_t out_q;
	logic          skid_valid_q;
	spe_pkg::res_t skid_q;

	// next-state values
	logic [PRESCALE_W-1:0] prescale_d;
	logic [PERIOD_W-1:0]   period_d;
	logic                  wrap;
	logic                  set_ok;
	logic [CMP_W-1:0]      new_cmp;
	logic [CMP_W-1:0]      active_d [CHANNELS];
	logic [LEVEL_W-1:0]    levels_d;
	spe_pkg::res_t         result;

	logic accept;
	logic out_take;

	assign cfg_ready = 1'b1;
	assign cmd_stall = skid_valid_q;
	assign accept    = cmd_valid && !cmd_stall;
	assign out_take  = out_valid_q && !res_stall;
	assign res_valid = out_valid_q;
	assign res_data  = out_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_top_q <= spe_pkg::PRESCALE_TOP_RST;
			period_top_q   <= spe_pkg::PERIOD_TOP_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				spe_pkg::REG_PRESCALE_TOP: prescale_top_q <= cfg_data[PRESCALE_W-1:0];
				spe_pkg::REG_PERIOD_TOP:   period_top_q   <= cfg_data[PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	// set-angle check and pulse width
	assign set_ok  = (cmd_data.command == spe_pkg::CMD_SET_ANGLE)
		&& (CHSEL_W'(cmd_data.channel) < CHSEL_W'(CHANNELS))
		&& (ANGCMP_W'(cmd_data.angle) <= ANGCMP_W'(MAX_ANGLE));
	assign new_cmp = spe_pkg::angle_to_compare(cmd_data.angle);

	// prescaler and period counter advance on a tick
	always_comb begin
		prescale_d = prescale_q;
		period_d   = period_q;
		wrap       = 1'b0;
		if (cmd_data.command == spe_pkg::CMD_TICK) begin
			if (prescale_q >= prescale_top_q) begin
				prescale_d = '0;
				if (period_q >= period_top_q) begin
					period_d = '0;
					wrap     = 1'b1;
				end else begin
					period_d = period_q + PERIOD_W'(1);
				end
			end else begin
				prescale_d = prescale_q + PRESCALE_W'(1);
			end
		end
	end

	// compares after this request
	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			active_d[i] = wrap ? preload_q[i] : active_q[i];
		end
	end

	// output levels from the updated counter and compares
	for (genvar g = 0; g < LEVEL_W; g++) begin : g_level
		if (g < CHANNELS) begin : g_on
			assign levels_d[g] = period_d < PERIOD_W'(active_d[g]);
		end else begin : g_off
			assign levels_d[g] = 1'b0;
		end
	end

	assign result.pwm_levels   = levels_d;
	assign result.period_start = wrap;
	assign result.accepted     = set_ok;

	// timer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q <= '0;
			period_q   <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				preload_q[i] <= '0;
				active_q[i]  <= '0;
			end
		end else if (accept) begin
			prescale_q <= prescale_d;
			period_q   <= period_d;
			for (int i = 0; i < CHANNELS; i++) begin
				active_q[i] <= active_d[i];
				if (set_ok && (cmd_data.channel == spe_pkg::CHAN_W'(i))) begin
					preload_q[i] <= new_cmp;
				end
			end
		end
	end

	// output valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (accept) begin
			if (out_valid_q && !out_take) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_q <= skid_q;
			end
		end else if (accept) begin
			if (out_valid_q && !out_take) begin
				skid_q <= result;
			end else begin
				out_q <= result;
			end
		end
	end

endmodule

// File: sv/spe_checker.sv
// port-level checks for the servo pwm block and their binding
module spe_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	input  logic                            cmd_stall,
	input  logic                            res_valid,
	input  logic                            res_stall,
	input  spe_pkg::res_t                   res_data
);

	// a waiting result stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result withdrawn while stalled");

	// a waiting result keeps its payload
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(res_data))
		else $error("result payload changed while stalled");

	// requests are held back only when a result is already waiting
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> res_valid)
		else $error("request stalled with empty output");

	// a result only appears after a request was taken
	a_res_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(cmd_valid && !cmd_stall))
		else $error("result without a request");

	// a request is either a tick or a set-angle, never both effects at once
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res_data.period_start && res_data.accepted))
		else $error("period start and set-angle ack together");

endmodule

bind servo_pwm_eight_channel spe_checker u_spe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_data  (res_data)
);
